/* rtl/stenc_pkg.sv */
// Shared types, constants and the digit pattern table for the speed/time
// segment encoder. No dependencies.
package stenc_pkg;

  localparam int unsigned SpeedW = 14;
  localparam int unsigned TimeW  = 19;

  localparam logic [SpeedW-1:0] SPEED_MAX = 14'd9999;
  localparam logic [TimeW-1:0]  TIME_MAX  = 19'd359999;

  // Reciprocal multipliers: q = (x * M) >> S, exact over each operand's range
  localparam logic [14:0] THOU_MUL = 15'd16778;    // x < 10000, shift 24
  localparam logic [20:0] HOUR_MUL = 21'd1193047;  // x < 360000, shift 32
  localparam logic [9:0]  HUND_MUL = 10'd656;      // x < 1000, shift 16
  localparam logic [12:0] MIN_MUL  = 13'd4370;     // x < 3600, shift 18
  localparam logic [6:0]  TEN_MUL  = 7'd103;       // x < 128, shift 10

  localparam logic [6:0] DASH_SEG = 7'h08;

  typedef struct packed {
    logic speed_blank;
    logic time_blank;
    logic rpm_icon_off;
    logic colon_off;
    logic time_is_set;
    logic show_thou;   // speed > 999
    logic show_hund;   // speed > 99
    logic show_tens;   // speed > 9
  } stenc_ctl_t;

  typedef struct packed {
    logic [3:0] spd_thou;
    logic [3:0] spd_hund;
    logic [3:0] spd_tens;
    logic [3:0] spd_unit;
    logic [3:0] hr_tens;
    logic [3:0] hr_unit;
    logic [3:0] mn_tens;
    logic [3:0] mn_unit;
  } stenc_digits_t;

  function automatic logic [6:0] seg_pat(input logic [3:0] d);
    logic [6:0] p;
    unique case (d)
      4'd0:    p = 7'h77;
      4'd1:    p = 7'h24;
      4'd2:    p = 7'h5D;
      4'd3:    p = 7'h6D;
      4'd4:    p = 7'h2E;
      4'd5:    p = 7'h6B;
      4'd6:    p = 7'h7B;
      4'd7:    p = 7'h25;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

endpackage

/* rtl/stenc_fmt.sv */
// Output stage: turns decimal digits into segment bytes, applies blanking,
// dashes and icons, and holds the word for the downstream side. Uses stenc_pkg.
module stenc_fmt import stenc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  stenc_digits_t digits_i,
  input  stenc_ctl_t    ctl_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [63:0]   m_axis_tdata_o   // digit1..digit8 segments, 8 bits each
);

  logic        vld_q, vld_d;
  logic [63:0] data_q, data_d;
  logic [6:0]  sp1, sp2, sp3, sp4, tp5, tp6, tp7, tp8;

  assign ready_o = !vld_q || m_axis_tready_i;

  always_comb begin
    sp1 = 7'h00;
    sp2 = 7'h00;
    sp3 = 7'h00;
    sp4 = 7'h00;
    if (!ctl_i.speed_blank) begin
      if (ctl_i.show_thou) sp1 = seg_pat(digits_i.spd_thou);
      if (ctl_i.show_hund) sp2 = seg_pat(digits_i.spd_hund);
      if (ctl_i.show_tens) sp3 = seg_pat(digits_i.spd_tens);
      sp4 = seg_pat(digits_i.spd_unit);
    end
    priority if (ctl_i.time_blank) begin
      tp5 = 7'h00;
      tp6 = 7'h00;
      tp7 = 7'h00;
      tp8 = 7'h00;
    end else if (!ctl_i.time_is_set) begin
      tp5 = DASH_SEG;
      tp6 = DASH_SEG;
      tp7 = DASH_SEG;
      tp8 = DASH_SEG;
    end else begin
      tp5 = seg_pat(digits_i.hr_tens);
      tp6 = seg_pat(digits_i.hr_unit);
      tp7 = seg_pat(digits_i.mn_tens);
      tp8 = seg_pat(digits_i.mn_unit);
    end
  end

  always_comb begin
    vld_d  = ready_o ? valid_i : vld_q;
    data_d = data_q;
    if (ready_o) begin
      data_d = {1'b1, tp8, 1'b0, tp7, !ctl_i.colon_off, tp6, 1'b0, tp5,
                !ctl_i.rpm_icon_off, sp4, 1'b0, sp3, 1'b0, sp2, 1'b0, sp1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;

  // min icon is always lit on a delivered word
  a_min_icon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> data_q[63])
    else $error("min icon missing");

  // a held word does not change while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !m_axis_tready_i) |=> (vld_q && $stable(data_q)))
    else $error("output word changed under stall");

endmodule

/* rtl/speed_time_segment_encoder.sv */
// Top level of the speed/time seven-segment encoder: input stage, constant
// division pipeline and output stage. Uses stenc_pkg and stenc_fmt.
//
//  port group  dir  tdata                                  tuser
//  s_axis      in   [13:0] speed_value, [32:14] time_secs  [4:0] flags
//  m_axis      out  [63:0] digit1..digit8 segment bytes    -
//
// Seven register stages from s_axis to m_axis; one word per cycle while m_axis
// is not stalled. The stages follow the chain of reciprocal multiplies and
// remainder subtracts (thousands/hours, hundreds/minutes, tens, units).
// Reset clears only the stage valid bits. A stall on m_axis fills the
// empty stages first; s_axis tready drops only when every stage holds a word.
module speed_time_segment_encoder import stenc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // speed_value, time_seconds, 7 unused bits
  input  logic [4:0]  s_axis_tuser_i,  // speed_blank, time_blank, rpm_icon_off,
                                       // colon_off, time_is_set
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // digit1 .. digit8 segments
);

  localparam int unsigned NStg = 6;

  logic [NStg-1:0] vld_q, vld_d;
  logic [NStg:0]   rdy;
  logic            fmt_rdy;

  // stage 1: saturated inputs
  logic [13:0] spd_sat;
  logic [18:0] tim_sat;
  stenc_ctl_t  ctl_in;
  logic [13:0] s1_spd_q;
  logic [18:0] s1_tim_q;

  // stage 2: thousands, hours
  logic [28:0] thou_prod;
  logic [39:0] hour_prod;
  logic [13:0] s2_spd_q;
  logic [18:0] s2_tim_q;
  logic [3:0]  s2_th_q;
  logic [6:0]  s2_hr_q;

  // stage 3: remainders
  logic [9:0]  s3_r1_q;
  logic [11:0] s3_rt_q;
  logic [3:0]  s3_th_q;
  logic [6:0]  s3_hr_q;

  // stage 4: hundreds, minutes, hours tens
  logic [19:0] hund_prod;
  logic [24:0] min_prod;
  logic [13:0] hrt_prod;
  logic [9:0]  s4_r1_q;
  logic [3:0]  s4_th_q;
  logic [6:0]  s4_hr_q;
  logic [3:0]  s4_hu_q;
  logic [5:0]  s4_mm_q;
  logic [3:0]  s4_ht_q;

  // stage 5
  logic [12:0] mnt_prod;
  logic [6:0]  s5_r2_q;
  logic [3:0]  s5_th_q, s5_hu_q, s5_ht_q, s5_hru_q, s5_mt_q;
  logic [5:0]  s5_mm_q;

  // stage 6
  logic [13:0] spt_prod;
  logic [6:0]  s6_r2_q;
  logic [3:0]  s6_th_q, s6_hu_q, s6_te_q, s6_ht_q, s6_hru_q, s6_mt_q, s6_mu_q;

  stenc_ctl_t    ctl_q [NStg];
  stenc_digits_t digits;

  always_comb begin
    rdy[NStg] = fmt_rdy;
    for (int i = NStg - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid_i : vld_q[0];
    for (int i = 1; i < NStg; i++) begin
      vld_d[i] = rdy[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  assign s_axis_tready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // input saturation and leading-zero flags
  always_comb begin
    spd_sat = (s_axis_tdata_i[13:0] > SPEED_MAX) ? SPEED_MAX : s_axis_tdata_i[13:0];
    tim_sat = (s_axis_tdata_i[32:14] > TIME_MAX) ? TIME_MAX : s_axis_tdata_i[32:14];
    ctl_in.speed_blank  = s_axis_tuser_i[0];
    ctl_in.time_blank   = s_axis_tuser_i[1];
    ctl_in.rpm_icon_off = s_axis_tuser_i[2];
    ctl_in.colon_off    = s_axis_tuser_i[3];
    ctl_in.time_is_set  = s_axis_tuser_i[4];
    ctl_in.show_thou    = spd_sat > 14'd999;
    ctl_in.show_hund    = spd_sat > 14'd99;
    ctl_in.show_tens    = spd_sat > 14'd9;
  end

  assign thou_prod = 29'(s1_spd_q) * 29'(THOU_MUL);
  assign hour_prod = 40'(s1_tim_q) * 40'(HOUR_MUL);
  assign hund_prod = 20'(s3_r1_q) * 20'(HUND_MUL);
  assign min_prod  = 25'(s3_rt_q) * 25'(MIN_MUL);
  assign hrt_prod  = 14'(s3_hr_q) * 14'(TEN_MUL);
  assign mnt_prod  = 13'(s4_mm_q) * 13'(TEN_MUL);
  assign spt_prod  = 14'(s5_r2_q) * 14'(TEN_MUL);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_spd_q <= spd_sat;
      s1_tim_q <= tim_sat;
      ctl_q[0] <= ctl_in;
    end
    if (rdy[1]) begin
      s2_spd_q <= s1_spd_q;
      s2_tim_q <= s1_tim_q;
      s2_th_q  <= thou_prod[27:24];
      s2_hr_q  <= hour_prod[38:32];
      ctl_q[1] <= ctl_q[0];
    end
    if (rdy[2]) begin
      s3_r1_q  <= 10'(s2_spd_q - 14'(s2_th_q) * 14'd1000);
      s3_rt_q  <= 12'(s2_tim_q - 19'(s2_hr_q) * 19'd3600);
      s3_th_q  <= s2_th_q;
      s3_hr_q  <= s2_hr_q;
      ctl_q[2] <= ctl_q[1];
    end
    if (rdy[3]) begin
      s4_r1_q  <= s3_r1_q;
      s4_th_q  <= s3_th_q;
      s4_hr_q  <= s3_hr_q;
      s4_hu_q  <= hund_prod[19:16];
      s4_mm_q  <= min_prod[23:18];
      s4_ht_q  <= hrt_prod[13:10];
      ctl_q[3] <= ctl_q[2];
    end
    if (rdy[4]) begin
      s5_r2_q  <= 7'(s4_r1_q - 10'(s4_hu_q) * 10'd100);
      s5_hru_q <= 4'(s4_hr_q - 7'(s4_ht_q) * 7'd10);
      s5_mt_q  <= {1'b0, mnt_prod[12:10]};
      s5_th_q  <= s4_th_q;
      s5_hu_q  <= s4_hu_q;
      s5_ht_q  <= s4_ht_q;
      s5_mm_q  <= s4_mm_q;
      ctl_q[4] <= ctl_q[3];
    end
    if (rdy[5]) begin
      s6_r2_q  <= s5_r2_q;
      s6_te_q  <= spt_prod[13:10];
      s6_mu_q  <= 4'(s5_mm_q - 6'(s5_mt_q) * 6'd10);
      s6_th_q  <= s5_th_q;
      s6_hu_q  <= s5_hu_q;
      s6_ht_q  <= s5_ht_q;
      s6_hru_q <= s5_hru_q;
      s6_mt_q  <= s5_mt_q;
      ctl_q[5] <= ctl_q[4];
    end
  end

  always_comb begin
    digits.spd_thou = s6_th_q;
    digits.spd_hund = s6_hu_q;
    digits.spd_tens = s6_te_q;
    digits.spd_unit = 4'(s6_r2_q - 7'(s6_te_q) * 7'd10);
    digits.hr_tens  = s6_ht_q;
    digits.hr_unit  = s6_hru_q;
    digits.mn_tens  = s6_mt_q;
    digits.mn_unit  = s6_mu_q;
  end

  stenc_fmt u_fmt (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (vld_q[NStg-1]),
    .ready_o         (fmt_rdy),
    .digits_i        (digits),
    .ctl_i           (ctl_q[NStg-1]),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // upstream only waits when the whole pipe is full and the output is stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i && (&vld_q)))
    else $error("input stalled with room in the pipe");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (s3_r1_q < 10'd1000 && s3_rt_q < 12'd3600 && s3_th_q < 4'd10))
    else $error("remainder out of range");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (s6_hu_q < 4'd10 && s6_te_q < 4'd10 && s6_hru_q < 4'd10 &&
                  s6_ht_q < 4'd10 && s6_mt_q < 4'd6 && s6_mu_q < 4'd10))
    else $error("decimal digit out of range");

endmodule
